// File: rtl/attr_sgr_pkg.sv
// Shared types, constants and character functions of the attribute-to-SGR converter.
`default_nettype none

package attr_sgr_pkg;

  // Default depth of the command queue between classifier and sequencer.
  localparam int FIFO_DEPTH_DEF = 2;

  // ASCII characters that appear in an SGR sequence.
  localparam logic [7:0] CHAR_ESC   = 8'h1b;
  localparam logic [7:0] CHAR_LBRK  = 8'h5b;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_FOUR  = 8'h34;
  localparam logic [7:0] CHAR_FIVE  = 8'h35;
  localparam logic [7:0] CHAR_M     = 8'h6d;

  // Attribute field positions and the terminal default colors.
  localparam int ATTR_BLINK_BIT = 7;
  localparam logic [3:0] FORE_DEFAULT = 4'h7;
  localparam logic [2:0] BACK_DEFAULT = 3'h0;

  // Fixed order of the positions in a sequence.
  localparam int SLOT_ESC    = 0;
  localparam int SLOT_LBRK   = 1;
  localparam int SLOT_RESET  = 2;
  localparam int SLOT_SEP_R  = 3;
  localparam int SLOT_INTENS = 4;
  localparam int SLOT_SEP_I  = 5;
  localparam int SLOT_FG_CMD = 6;
  localparam int SLOT_FG_DIG = 7;
  localparam int SLOT_SEP_F  = 8;
  localparam int SLOT_BG_CMD = 9;
  localparam int SLOT_BG_DIG = 10;
  localparam int SLOT_SEP_B  = 11;
  localparam int SLOT_BLINK  = 12;
  localparam int SLOT_END    = 13;
  localparam int NUM_SLOTS   = 14;

  // PC color order (bit 0 blue) to ANSI color order (bit 0 red).
  localparam logic [2:0] ANSI_ORDER [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef struct packed {
    logic [7:0] new_attr;
    logic [7:0] old_attr;
    logic       old_valid;
  } sgr_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } sgr_out_t;

  // One classified request: which positions are present and their variable characters.
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           int_char;
    logic [7:0]           fg_char;
    logic [7:0]           bg_char;
  } sgr_cmd_t;

  // ASCII digit of a PC color in ANSI numbering.
  function automatic logic [7:0] color_char(input logic [2:0] pc_color);
    return CHAR_ZERO + {5'b0, ANSI_ORDER[pc_color]};
  endfunction

  // Character sent at a given position of a request.
  function automatic logic [7:0] slot_char(input int slot, input sgr_cmd_t cmd);
    logic [7:0] ch;
    unique case (slot)
      SLOT_ESC:    ch = CHAR_ESC;
      SLOT_LBRK:   ch = CHAR_LBRK;
      SLOT_RESET:  ch = CHAR_ZERO;
      SLOT_SEP_R:  ch = CHAR_SEMI;
      SLOT_INTENS: ch = cmd.int_char;
      SLOT_SEP_I:  ch = CHAR_SEMI;
      SLOT_FG_CMD: ch = CHAR_THREE;
      SLOT_FG_DIG: ch = cmd.fg_char;
      SLOT_SEP_F:  ch = CHAR_SEMI;
      SLOT_BG_CMD: ch = CHAR_FOUR;
      SLOT_BG_DIG: ch = cmd.bg_char;
      SLOT_SEP_B:  ch = CHAR_SEMI;
      SLOT_BLINK:  ch = CHAR_FIVE;
      SLOT_END:    ch = CHAR_M;
      default:     ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/text_attribute_to_ansi_sgr_top.sv
// Top level of the PC text attribute to ANSI SGR sequence converter.
//
// Input channel (in_valid, in_stall, in_data) takes a new attribute, the old
// attribute and a flag that says whether the old one exists. Output channel
// (out_valid, out_stall, out_data) returns the SGR sequence one character per
// request, with last_char set on the closing 'm'. Equal attributes with a known
// predecessor are taken and produce no characters.
// With the sequencer idle, an item taken is first written into the request
// queue, and its ESC is then loaded into the output register.
// Throughput: the sequencer sends one character per cycle while the receiver
// does not stall; a sequence has 4 to 12 characters. The classifier takes a new
// item every cycle while the request queue (FIFO_DEPTH entries) has room, so
// items are taken while an earlier sequence is still being sent.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// When the receiver stalls, the current character holds, the sequencer waits,
// and once the queue fills in_stall rises.
`default_nettype none

module text_attribute_to_ansi_sgr_top #(
  parameter int FIFO_DEPTH = attr_sgr_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire attr_sgr_pkg::sgr_in_t in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output attr_sgr_pkg::sgr_out_t     out_data
);
  import attr_sgr_pkg::*;

  logic     q_push, q_pop, q_full, q_empty;
  sgr_cmd_t q_push_cmd, q_pop_cmd;

  // Classifier.
  attr_sgr_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // Request queue.
  attr_sgr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  // Character sequencer.
  attr_sgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/attr_sgr_front.sv
// Front end: accepts attribute pairs and classifies them into sequence requests.
`default_nettype none

module attr_sgr_front (
  input  wire logic                  in_valid,
  input  wire attr_sgr_pkg::sgr_in_t in_data,
  output logic                       in_stall,
  input  wire logic                  q_full,
  output logic                       q_push,
  output attr_sgr_pkg::sgr_cmd_t     q_cmd
);
  import attr_sgr_pkg::*;

  logic       blink;
  logic [3:0] fore;
  logic [2:0] back;
  logic       same;
  logic       oblink;
  logic       rst_seq;
  logic [3:0] ofore2;
  logic [2:0] oback2;
  logic       onone2;
  logic       fdiff;
  logic       idiff;
  logic       dark;
  logic [3:0] ofore3;
  logic [2:0] oback3;
  logic       onone3;
  logic       fg_emit;
  logic       bdiff;

  // The queue must have room before an item is taken.
  assign in_stall = q_full;

  // Equal attributes with a known predecessor produce no request.
  assign same   = in_data.old_valid && (in_data.new_attr == in_data.old_attr);
  assign q_push = in_valid && !q_full && !same;

  assign blink = in_data.new_attr[ATTR_BLINK_BIT];
  assign fore  = in_data.new_attr[3:0];
  assign back  = in_data.new_attr[6:4];

  // Without a predecessor the old blink counts as set and the old colors as unknown.
  assign oblink  = in_data.old_valid ? in_data.old_attr[ATTR_BLINK_BIT] : 1'b1;
  assign rst_seq = oblink && !blink;

  // A reset code returns the terminal to its default colors.
  assign ofore2 = rst_seq ? FORE_DEFAULT : in_data.old_attr[3:0];
  assign oback2 = rst_seq ? BACK_DEFAULT : in_data.old_attr[6:4];
  assign onone2 = !in_data.old_valid && !rst_seq;

  // Intensity change; going dark also resets the colors.
  assign fdiff  = onone2 || (fore != ofore2);
  assign idiff  = fdiff && (onone2 || (fore[3] != ofore2[3]));
  assign dark   = idiff && !fore[3];
  assign ofore3 = dark ? FORE_DEFAULT : ofore2;
  assign oback3 = dark ? BACK_DEFAULT : oback2;
  assign onone3 = onone2 && !dark;

  assign fg_emit = fdiff && (onone3 || (fore != ofore3));
  assign bdiff   = onone3 || (back != oback3);

  // Assemble the request.
  always_comb begin
    q_cmd.mask              = '0;
    q_cmd.mask[SLOT_ESC]    = 1'b1;
    q_cmd.mask[SLOT_LBRK]   = 1'b1;
    q_cmd.mask[SLOT_RESET]  = rst_seq;
    q_cmd.mask[SLOT_SEP_R]  = rst_seq && ((fore != FORE_DEFAULT) || (back != BACK_DEFAULT));
    q_cmd.mask[SLOT_INTENS] = idiff;
    q_cmd.mask[SLOT_SEP_I]  = idiff &&
                              (onone3 || (fore != ofore3) || (back != oback3) || blink);
    q_cmd.mask[SLOT_FG_CMD] = fg_emit;
    q_cmd.mask[SLOT_FG_DIG] = fg_emit;
    q_cmd.mask[SLOT_SEP_F]  = fg_emit && (bdiff || blink);
    q_cmd.mask[SLOT_BG_CMD] = bdiff;
    q_cmd.mask[SLOT_BG_DIG] = bdiff;
    q_cmd.mask[SLOT_SEP_B]  = bdiff && blink;
    q_cmd.mask[SLOT_BLINK]  = blink;
    q_cmd.mask[SLOT_END]    = 1'b1;
    q_cmd.int_char          = fore[3] ? CHAR_ONE : CHAR_ZERO;
    q_cmd.fg_char           = color_char(fore[2:0]);
    q_cmd.bg_char           = color_char(back);
  end

endmodule

`default_nettype wire

// File: rtl/attr_sgr_fifo.sv
// Request queue between the classifier and the character sequencer.
`default_nettype none

module attr_sgr_fifo #(
  parameter int DEPTH = attr_sgr_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire attr_sgr_pkg::sgr_cmd_t push_cmd,
  output logic                        full,
  input  wire logic                   pop,
  output attr_sgr_pkg::sgr_cmd_t      pop_cmd,
  output logic                        empty
);
  import attr_sgr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sgr_cmd_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage is payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/attr_sgr_back.sv
// Back end: walks each request's positions and sends one character per cycle while the output is not stalled.
`default_nettype none

module attr_sgr_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire attr_sgr_pkg::sgr_cmd_t q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output attr_sgr_pkg::sgr_out_t      out_data
);
  import attr_sgr_pkg::*;

  logic [NUM_SLOTS-1:0] mask_r, mask_nxt;
  sgr_cmd_t             cmd_r, cmd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sgr_out_t             out_data_r, out_data_nxt;
  logic                 advance;
  logic                 have;
  sgr_cmd_t             src_cmd;
  logic [NUM_SLOTS-1:0] src_mask;
  logic [NUM_SLOTS-1:0] pick;
  logic [7:0]           pick_char;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The output register moves when it is empty or being taken.
  assign advance = !out_valid_r || !out_stall;
  assign have    = |mask_r;

  // Work from the current request, or from the queue head once it is done.
  always_comb begin
    src_cmd  = have ? cmd_r : q_cmd;
    src_mask = have ? mask_r : q_cmd.mask;
    pick     = src_mask & (~src_mask + 1'b1);
    pick_char = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) begin
        pick_char = pick_char | slot_char(i, src_cmd);
      end
    end
  end

  // Sequencing of characters.
  always_comb begin
    q_pop         = 1'b0;
    mask_nxt      = mask_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      if (have || !q_empty) begin
        q_pop                  = !have;
        cmd_nxt                = src_cmd;
        mask_nxt               = src_mask & ~pick;
        out_valid_nxt          = 1'b1;
        out_data_nxt.out_char  = pick_char;
        out_data_nxt.last_char = pick[SLOT_END];
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/attr_sgr_chk.sv
// Port checker of the converter and its binding to the top level.
`default_nettype none

module attr_sgr_chk (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire attr_sgr_pkg::sgr_in_t  in_data,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire attr_sgr_pkg::sgr_out_t out_data
);
  import attr_sgr_pkg::*;

  // A stalled input request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input request changed while stalled");

  // A stalled character stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output character changed while stalled");

  // Reset leaves the output channel empty.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The last flag marks exactly the closing 'm'.
  a_last_m: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_char == (out_data.out_char == CHAR_M)))
    else $error("last flag does not match the closing character");

  // An escape is followed at once by the opening bracket.
  a_esc_brk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.out_char == CHAR_ESC)
      |=> out_valid && (out_data.out_char == CHAR_LBRK))
    else $error("escape not followed by bracket");

endmodule

bind text_attribute_to_ansi_sgr_top attr_sgr_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
